// ----- rtl/plins_pkg.sv -----
// ---------------------------------------------------------------------------
// plins_pkg: shared types and constants
// Key and handle widths, operation codes and controller states.
// ---------------------------------------------------------------------------
package plins_pkg;

  localparam int KEY_BITS    = 16;
  localparam int HANDLE_BITS = 16;
  localparam int CNT_BITS    = 17;
  localparam int NODE_BITS   = KEY_BITS + 1;
  localparam int NUM_KEYS    = 1 << KEY_BITS;
  localparam int NUM_NODES   = 1 << NODE_BITS;

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_REPLACE = 3'd1;
  localparam logic [2:0] OP_REMOVE  = 3'd2;
  localparam logic [2:0] OP_GET     = 3'd3;
  localparam logic [2:0] OP_BELOW   = 3'd4;
  localparam logic [2:0] OP_ABOVE   = 3'd5;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HREAD,
    ST_HDEC,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DESC_RD,
    ST_DESC_CHK,
    ST_LEAF_RD,
    ST_LEAF_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic hrd;
    logic hwr;
    logic crd;
    logic cwr;
    logic up;
    logic climb;
    logic go_sib;
    logic go_child;
    logic set_res;
    logic clr_res;
    logic lrd;
    logic res_from_leaf;
  } ctl_t;

  typedef struct packed {
    logic clr_done;
    logic occ;
    logic new_zero;
    logic [2:0] op;
    logic at_root;
    logic sib_hit;
    logic at_leaf;
    logic cnt_nz;
    logic res_nz;
  } sts_t;

endpackage

// ----- rtl/plins_if.sv -----
// ---------------------------------------------------------------------------
// plins_if: valid/ready channel
// Carries one word with valid and ready handshake.
// ---------------------------------------------------------------------------
interface plins_in_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         opcode;
  logic [15:0]                        key;
  logic [15:0]                        handle;
  modport source (output valid, opcode, key, handle, input ready);
  modport sink   (input valid, opcode, key, handle, output ready);
endinterface

interface plins_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_handle;
  logic        found;
  modport source (output valid, result_handle, found, input ready);
  modport sink   (input valid, result_handle, found, output ready);
endinterface

// ----- rtl/plins_datapath.sv -----
// ---------------------------------------------------------------------------
// plins_datapath: count tree and handle store
// Holds both memories, the node pointer and the result register.
// ---------------------------------------------------------------------------
module plins_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  plins_pkg::ctl_t                  ctl,
  input  logic [2:0]                       in_op,
  input  logic [plins_pkg::KEY_BITS-1:0]   in_key,
  input  logic [plins_pkg::HANDLE_BITS-1:0] in_handle,
  output plins_pkg::sts_t                  sts,
  output logic [15:0]                      res
);
  localparam int KB = plins_pkg::KEY_BITS;
  localparam int HB = plins_pkg::HANDLE_BITS;
  localparam int NB = plins_pkg::NODE_BITS;
  localparam int CB = plins_pkg::CNT_BITS;

  logic [CB-1:0] cnt_mem [plins_pkg::NUM_NODES];
  logic [HB-1:0] h_mem   [plins_pkg::NUM_KEYS];

  logic [2:0]    op_r;
  logic [KB-1:0] key_r;
  logic [HB-1:0] hnew_r;
  logic [NB-1:0] node_r, node_nxt;
  logic [NB-1:0] clr_r;
  logic [CB-1:0] cnt_q_r;
  logic [HB-1:0] h_q_r;
  logic [HB-1:0] res_r;
  logic [NB-1:0] caddr;
  logic [NB-1:0] sib;
  logic [NB-1:0] child;

  // Sibling on the search side: left for below, right for above.
  assign sib = (op_r == plins_pkg::OP_ABOVE) ? (node_r + NB'(1)) : (node_r - NB'(1));

  // Preferred child: right when searching below, left when searching above.
  assign child = (op_r == plins_pkg::OP_BELOW) ? {node_r[NB-2:0], 1'b1}
                                               : {node_r[NB-2:0], 1'b0};

  always_comb begin
    caddr = node_r;
    if (ctl.clr_step) caddr = clr_r;
    else if (ctl.go_sib) caddr = sib;
    else if (ctl.go_child) caddr = child;
  end

  always_ff @(posedge clk) begin
    if (ctl.cwr) cnt_mem[caddr] <= ctl.clr_step ? '0 :
                                   (ctl.up ? cnt_q_r + CB'(1) : cnt_q_r - CB'(1));
    if (ctl.crd) cnt_q_r <= cnt_mem[caddr];
    if (ctl.hwr) h_mem[ctl.clr_step ? clr_r[KB-1:0] : key_r] <=
                   (ctl.clr_step || op_r == plins_pkg::OP_REMOVE) ? '0 : hnew_r;
    if (ctl.hrd) h_q_r <= h_mem[key_r];
    if (ctl.lrd) h_q_r <= h_mem[node_r[KB-1:0]];
  end

  always_comb begin
    node_nxt = node_r;
    if (ctl.load) node_nxt = {1'b1, in_key};
    else if (ctl.climb) node_nxt = node_r >> 1;
    else if (ctl.go_sib) node_nxt = sib;
    else if (ctl.go_child) node_nxt = child;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (ctl.clr_step) begin
      clr_r <= clr_r + NB'(1);
    end else if (ctl.load) begin
      clr_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r   <= in_op;
      key_r  <= in_key;
      hnew_r <= in_handle;
    end
    node_r <= node_nxt;
    if (ctl.clr_res) res_r <= '0;
    else if (ctl.set_res || ctl.res_from_leaf) res_r <= h_q_r;
  end

  // When the probed child is empty the controller moves to its sibling, which
  // is then occupied because the parent count is nonzero.
  assign sts.clr_done = (clr_r == '1);
  assign sts.occ      = (h_q_r != '0);
  assign sts.new_zero = (hnew_r == '0);
  assign sts.op       = op_r;
  assign sts.at_root  = (node_r == NB'(1));
  assign sts.sib_hit  = (op_r == plins_pkg::OP_ABOVE) ? ~node_r[0] : node_r[0];
  assign sts.at_leaf  = node_r[NB-1];
  assign sts.cnt_nz   = (cnt_q_r != '0);
  assign sts.res_nz   = (res_r != '0);
  assign res = 16'(res_r);
endmodule

// ----- rtl/plins_ctrl.sv -----
// ---------------------------------------------------------------------------
// plins_ctrl: operation sequencer
// Clears the stores after reset, then steps each operation through the tree.
// ---------------------------------------------------------------------------
module plins_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  plins_pkg::sts_t sts,
  output plins_pkg::ctl_t ctl
);
  plins_pkg::state_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= plins_pkg::ST_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      plins_pkg::ST_CLEAR:  if (sts.clr_done) st_nxt = plins_pkg::ST_IDLE;
      plins_pkg::ST_IDLE:   if (in_valid) st_nxt = plins_pkg::ST_HREAD;
      plins_pkg::ST_HREAD:  st_nxt = plins_pkg::ST_HDEC;
      plins_pkg::ST_HDEC: begin
        case (sts.op)
          plins_pkg::OP_INSERT, plins_pkg::OP_REPLACE, plins_pkg::OP_REMOVE: begin
            if ((sts.op == plins_pkg::OP_REPLACE && !sts.occ) ||
                (sts.op == plins_pkg::OP_REMOVE && !sts.occ) ||
                (sts.occ == !sts.new_zero && sts.op != plins_pkg::OP_REMOVE))
              st_nxt = plins_pkg::ST_DONE;
            else
              st_nxt = plins_pkg::ST_UPD_RD;
          end
          plins_pkg::OP_BELOW, plins_pkg::OP_ABOVE:
            st_nxt = sts.occ ? plins_pkg::ST_DONE : plins_pkg::ST_SCAN_CHK;
          default: st_nxt = plins_pkg::ST_DONE;
        endcase
      end
      plins_pkg::ST_UPD_RD: st_nxt = plins_pkg::ST_UPD_WR;
      plins_pkg::ST_UPD_WR: st_nxt = sts.at_root ? plins_pkg::ST_DONE : plins_pkg::ST_UPD_RD;
      plins_pkg::ST_SCAN_CHK: begin
        if (sts.at_root) st_nxt = plins_pkg::ST_DONE;
        else if (sts.sib_hit) st_nxt = plins_pkg::ST_SCAN_RD;
      end
      plins_pkg::ST_SCAN_RD:
        st_nxt = sts.cnt_nz ? (sts.at_leaf ? plins_pkg::ST_LEAF_RD : plins_pkg::ST_DESC_RD)
                            : plins_pkg::ST_SCAN_CHK;
      plins_pkg::ST_DESC_RD:   st_nxt = plins_pkg::ST_DESC_CHK;
      plins_pkg::ST_DESC_CHK:
        st_nxt = sts.at_leaf ? plins_pkg::ST_LEAF_RD : plins_pkg::ST_DESC_RD;
      plins_pkg::ST_LEAF_RD:   st_nxt = plins_pkg::ST_LEAF_WAIT;
      plins_pkg::ST_LEAF_WAIT: st_nxt = plins_pkg::ST_DONE;
      plins_pkg::ST_DONE:      if (out_ready) st_nxt = plins_pkg::ST_IDLE;
      default:                 st_nxt = plins_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (st_r)
      plins_pkg::ST_CLEAR: begin
        ctl.clr_step = 1'b1;
        ctl.cwr      = 1'b1;
        ctl.hwr      = 1'b1;
      end
      plins_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.load    = in_valid;
        ctl.clr_res = 1'b1;
      end
      plins_pkg::ST_HREAD: ctl.hrd = 1'b1;
      plins_pkg::ST_HDEC: begin
        if (sts.op == plins_pkg::OP_GET ||
            ((sts.op == plins_pkg::OP_BELOW || sts.op == plins_pkg::OP_ABOVE) && sts.occ))
          ctl.set_res = 1'b1;
        if ((sts.op == plins_pkg::OP_INSERT) ||
            (sts.op == plins_pkg::OP_REPLACE && sts.occ) ||
            (sts.op == plins_pkg::OP_REMOVE && sts.occ))
          ctl.hwr = 1'b1;
      end
      plins_pkg::ST_UPD_RD: ctl.crd = 1'b1;
      plins_pkg::ST_UPD_WR: begin
        ctl.cwr   = 1'b1;
        ctl.up    = (sts.op == plins_pkg::OP_INSERT) && !sts.new_zero;
        ctl.climb = 1'b1;
      end
      plins_pkg::ST_SCAN_CHK: begin
        if (!sts.at_root) begin
          if (sts.sib_hit) begin
            ctl.go_sib = 1'b1;
            ctl.crd    = 1'b1;
          end else ctl.climb = 1'b1;
        end
      end
      plins_pkg::ST_SCAN_RD: begin
        // Empty sibling: move up to the parent it shares with our node.
        if (!sts.cnt_nz) ctl.climb = 1'b1;
      end
      plins_pkg::ST_DESC_RD: begin
        ctl.go_child = 1'b1;
        ctl.crd      = 1'b1;
      end
      plins_pkg::ST_DESC_CHK: begin
        if (!sts.cnt_nz) ctl.go_sib = 1'b1;
      end
      plins_pkg::ST_LEAF_RD:   ctl.lrd = 1'b1;
      plins_pkg::ST_LEAF_WAIT: ctl.res_from_leaf = 1'b1;
      plins_pkg::ST_DONE:      out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

// ----- rtl/price_level_index_nearest_search.sv -----
// ---------------------------------------------------------------------------
// price_level_index_nearest_search: sparse key map with nearest search
// Handle store plus a count tree, one level per key bit.
// ---------------------------------------------------------------------------
// Channel   Dir  Word
// in_       in   opcode, key, handle
// out_      out  result_handle, found
//
// One operation at a time: updates read and then write the single-port count
// memory at each level from the leaf up to the root; nearest searches climb to
// the first nonempty sibling and then descend to a leaf. After reset a clearing
// pass over every node runs before the first word is taken. A stalled result
// holds the block until it is taken.
module price_level_index_nearest_search (
  input logic         clk,
  input logic         rst_n,
  plins_in_if.sink    in_ch,
  plins_out_if.source out_ch
);
  plins_pkg::ctl_t ctl;
  plins_pkg::sts_t sts;
  logic [15:0]     res;

  plins_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .ctl
  );

  plins_datapath u_dp (
    .clk, .rst_n, .ctl,
    .in_op    (in_ch.opcode),
    .in_key   (in_ch.key[plins_pkg::KEY_BITS-1:0]),
    .in_handle(in_ch.handle[plins_pkg::HANDLE_BITS-1:0]),
    .sts, .res
  );

  assign out_ch.result_handle = res;
  assign out_ch.found         = sts.res_nz;
endmodule
